### src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Types and constants shared by the framed byte receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned SYNC_COUNT = 5;
  localparam int unsigned MAX_LEN    = 128;

  localparam logic [7:0] CAPACITY_RESET   = 8'd255;
  localparam logic [7:0] SYNC_CODE_RESET  = 8'd22;
  localparam logic [7:0] START_CODE_RESET = 8'd2;
  localparam logic [7:0] END_CODE_RESET   = 8'd3;

  typedef enum logic [1:0] {
    REG_BUFFER_CAPACITY = 2'd0,
    REG_SYNC_CODE       = 2'd1,
    REG_START_CODE      = 2'd2,
    REG_END_CODE        = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_SYNC   = 3'd0,
    PH_START  = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5,
    PH_END    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_CHECKSUM = 3'd1,
    ST_BAD_END      = 3'd2,
    ST_TOO_LONG     = 3'd3,
    ST_OVERFLOW     = 3'd4
  } status_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [2:0] status;
    logic [7:0] frame_length;
  } result_t;

endpackage

### src/stx_etx_frame_receiver.sv
// ----------------------------------------------------------------------------
// Framed byte receiver
// Hunts for sync and start bytes, passes payload bytes on and reports a
// status item at the end of each frame.
// ----------------------------------------------------------------------------
// A result item is registered into the output register, or into the skid
// register while the output holds one. One byte per cycle while not stalled;
// the frame state updates on each accepted byte. The two registers let bytes
// keep coming while a result waits; input stalls only when both hold an item.
// Reset clears the frame state and loads the default register values.
module stx_etx_frame_receiver
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       kind,
  output logic [7:0] data_byte,
  output logic [7:0] byte_index,
  output logic [2:0] status,
  output logic [7:0] frame_length
);

  localparam logic [2:0] SYNC_LAST = 3'(SYNC_COUNT - 1);
  localparam logic [7:0] LEN_LIMIT = 8'(MAX_LEN);

  logic [7:0] buffer_capacity;
  logic [7:0] sync_code;
  logic [7:0] start_code;
  logic [7:0] end_code;

  phase_t     phase, phase_next;
  logic [2:0] sync_seen, sync_seen_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] bytes_taken, bytes_taken_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] sent_checksum, sent_checksum_next;

  result_t    result_new;
  logic       has_result;
  result_t    out_item;
  logic       out_valid;
  result_t    skid_item;
  logic       skid_valid;

  logic       accept;
  logic       pop;
  logic       push;
  logic [7:0] taken_inc;

  assign rx_stall = skid_valid;
  assign accept   = rx_valid && !rx_stall;
  assign pop      = out_valid && !res_stall;
  assign push     = accept && has_result;
  assign taken_inc = bytes_taken + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity <= CAPACITY_RESET;
      sync_code       <= SYNC_CODE_RESET;
      start_code      <= START_CODE_RESET;
      end_code        <= END_CODE_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_BUFFER_CAPACITY: buffer_capacity <= cfg_data;
        REG_SYNC_CODE:       sync_code       <= cfg_data;
        REG_START_CODE:      start_code      <= cfg_data;
        REG_END_CODE:        end_code        <= cfg_data;
        default:             ;
      endcase
    end
  end

  always_comb begin
    phase_next           = phase;
    sync_seen_next       = sync_seen;
    declared_length_next = declared_length;
    bytes_taken_next     = bytes_taken;
    running_sum_next     = running_sum;
    sent_checksum_next   = sent_checksum;
    has_result           = 1'b0;
    result_new           = '0;
    case (phase)
      PH_START: begin
        if (rx_byte == start_code) begin
          phase_next = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        declared_length_next = rx_byte;
        bytes_taken_next     = '0;
        running_sum_next     = '0;
        if (rx_byte > LEN_LIMIT) begin
          has_result              = 1'b1;
          result_new.kind         = 1'b1;
          result_new.status       = ST_TOO_LONG;
          result_new.frame_length = rx_byte;
          phase_next              = PH_SYNC;
          sync_seen_next          = '0;
        end else if (rx_byte == 8'd0) begin
          phase_next = PH_CHECK;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        has_result = 1'b1;
        if (bytes_taken >= buffer_capacity) begin
          result_new.kind         = 1'b1;
          result_new.status       = ST_OVERFLOW;
          result_new.frame_length = declared_length;
          phase_next              = PH_SYNC;
          sync_seen_next          = '0;
        end else begin
          result_new.data_byte = rx_byte;
          result_new.byte_index = bytes_taken;
          running_sum_next     = running_sum + rx_byte;
          bytes_taken_next     = taken_inc;
          if (taken_inc >= declared_length) begin
            phase_next = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        sent_checksum_next = rx_byte;
        phase_next         = PH_END;
      end
      PH_END: begin
        has_result              = 1'b1;
        result_new.kind         = 1'b1;
        result_new.frame_length = declared_length;
        if (rx_byte != end_code) begin
          result_new.status = ST_BAD_END;
        end else if (sent_checksum != running_sum) begin
          result_new.status = ST_BAD_CHECKSUM;
        end else begin
          result_new.status = ST_OK;
        end
        phase_next     = PH_SYNC;
        sync_seen_next = '0;
      end
      default: begin
        phase_next = PH_SYNC;
        if (rx_byte == sync_code) begin
          if (sync_seen >= SYNC_LAST) begin
            sync_seen_next = '0;
            phase_next     = PH_START;
          end else begin
            sync_seen_next = sync_seen + 3'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC;
      sync_seen       <= '0;
      declared_length <= '0;
      bytes_taken     <= '0;
      running_sum     <= '0;
      sent_checksum   <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      sync_seen       <= sync_seen_next;
      declared_length <= declared_length_next;
      bytes_taken     <= bytes_taken_next;
      running_sum     <= running_sum_next;
      sent_checksum   <= sent_checksum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_item  <= result_new;
        out_valid <= 1'b1;
      end else begin
        skid_item  <= result_new;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign res_valid    = out_valid;
  assign kind         = out_item.kind;
  assign data_byte    = out_item.data_byte;
  assign byte_index   = out_item.byte_index;
  assign status       = out_item.status;
  assign frame_length = out_item.frame_length;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an item while the output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && res_stall) |=> (skid_valid && $stable(skid_item)))
    else $error("skid item lost while the output is stalled");

  a_data_status_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !kind) |-> (status == ST_OK && frame_length == 8'd0))
    else $error("payload item carries status fields");

  a_sync_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SYNC) |-> (sync_seen <= SYNC_LAST))
    else $error("sync count ran past its limit");

  a_data_index: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_taken < declared_length))
    else $error("data phase with all declared bytes already taken");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed byte receiver testbench
// Sends sync-start-length-payload-checksum-end frames, broken frames and
// stray bytes to the receiver. A predictor in the bench tracks the frame
// state and queues the expected payload and status items. Each item on the
// result side is compared field by field with the oldest one queued. Both
// sides idle and stall at random, and the registers are rewritten between
// frames.
// ----------------------------------------------------------------------------
module tb_top;
  import sfr_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int WATCHDOG_LIMIT = 4000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_BUFFER_CAPACITY;
  logic [7:0] cfg_data = 8'd0;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [2:0] status;
  logic [7:0] frame_length;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  logic [7:0] cap_limit;
  logic [7:0] sync_char;
  logic [7:0] start_char;
  logic [7:0] end_char;
  phase_t     rx_phase;
  logic [2:0] syncs_seen;
  logic [7:0] frame_len;
  logic [7:0] taken_count;
  logic [7:0] payload_sum;
  logic [7:0] rx_checksum;

  result_t expected_results[$];
  result_t due_result;

  stx_etx_frame_receiver i_dut (.*);

  always #1 clk = ~clk;

  always @(negedge clk) begin
    res_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  function automatic void reset_model();
    cap_limit   = CAPACITY_RESET;
    sync_char   = SYNC_CODE_RESET;
    start_char  = START_CODE_RESET;
    end_char    = END_CODE_RESET;
    rx_phase    = PH_SYNC;
    syncs_seen  = '0;
    frame_len   = '0;
    taken_count = '0;
    payload_sum = '0;
    rx_checksum = '0;
  endfunction

  function automatic void close_frame(input status_t code);
    expected_results.push_back('{kind: 1'b1, data_byte: 8'd0, byte_index: 8'd0,
                                 status: code, frame_length: frame_len});
    rx_phase   = PH_SYNC;
    syncs_seen = '0;
  endfunction

  function automatic void model_byte(input logic [7:0] value);
    case (rx_phase)
      PH_START: begin
        if (value == start_char) rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        rx_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len   = value;
        taken_count = '0;
        payload_sum = '0;
        if (value > MAX_LEN) close_frame(ST_TOO_LONG);
        else rx_phase = (value == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        if (taken_count >= cap_limit) begin
          close_frame(ST_OVERFLOW);
        end else begin
          expected_results.push_back('{kind: 1'b0, data_byte: value, byte_index: taken_count,
                                       status: ST_OK, frame_length: 8'd0});
          payload_sum = payload_sum + value;
          taken_count = taken_count + 8'd1;
          if (taken_count >= frame_len) rx_phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        rx_checksum = value;
        rx_phase    = PH_END;
      end
      PH_END: begin
        if (value != end_char) close_frame(ST_BAD_END);
        else if (rx_checksum != payload_sum) close_frame(ST_BAD_CHECKSUM);
        else close_frame(ST_OK);
      end
      default: begin
        rx_phase = PH_SYNC;
        if (value == sync_char) begin
          syncs_seen = syncs_seen + 3'd1;
          if (syncs_seen >= SYNC_COUNT) begin
            syncs_seen = '0;
            rx_phase   = PH_START;
          end
        end
      end
    endcase
  endfunction

  function automatic byte_q_t random_payload(input int count);
    byte_q_t payload;
    for (int i = 0; i < count; i++) payload.push_back(8'($urandom));
    return payload;
  endfunction

  function automatic int pick_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(0, 12);
    if (pick < 85) return $urandom_range(13, 40);
    if (pick < 92) return $urandom_range(41, MAX_LEN);
    if (pick < 97) return $urandom_range(MAX_LEN + 1, 255);
    return MAX_LEN;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("result item %0d at %0t: %s", results_checked, $realtime, what);
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_stall == 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with none expected");
      end else begin
        due_result = expected_results.pop_front();
        if (kind !== due_result.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", kind, due_result.kind));
        if (data_byte !== due_result.data_byte)
          report_mismatch($sformatf("data_byte %0h, expected %0h", data_byte,
                                    due_result.data_byte));
        if (byte_index !== due_result.byte_index)
          report_mismatch($sformatf("byte_index %0d, expected %0d", byte_index,
                                    due_result.byte_index));
        if (status !== due_result.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, due_result.status));
        if (frame_length !== due_result.frame_length)
          report_mismatch($sformatf("frame_length %0d, expected %0d", frame_length,
                                    due_result.frame_length));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if ((rx_valid && rx_stall === 1'b0) || (res_valid === 1'b1 && !res_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= value;
    @(posedge clk);
    while (rx_stall !== 1'b0) @(posedge clk);
    model_byte(value);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    rx_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t index, input logic [7:0] value);
    wait_for_results();
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (index)
      REG_BUFFER_CAPACITY: cap_limit = value;
      REG_SYNC_CODE:       sync_char = value;
      REG_START_CODE:      start_char = value;
      default:             end_char = value;
    endcase
  endtask

  task automatic send_noise(input int count);
    logic [7:0] value;
    repeat (count) begin
      do value = 8'($urandom); while (value == sync_char || value == start_char);
      send_byte(value);
    end
  endtask

  task automatic send_garbage(input int count);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: send_byte(sync_char);
        1: send_byte(start_char);
        2: send_byte(end_char);
        default: send_byte(8'($urandom));
      endcase
    end
  endtask

  task automatic send_frame(input logic [7:0] len, input byte_q_t payload, input bit sum_ok,
                            input bit end_ok, input int noise_max);
    logic [7:0] payload_total;
    payload_total = '0;
    for (int i = 0; i < SYNC_COUNT; i++) begin
      send_noise($urandom_range(0, noise_max));
      send_byte(sync_char);
    end
    send_noise($urandom_range(0, noise_max));
    send_byte(start_char);
    send_byte(8'($urandom));
    send_byte(len);
    if (len > MAX_LEN) return;
    foreach (payload[i]) begin
      send_byte(payload[i]);
      payload_total = payload_total + payload[i];
    end
    send_byte(sum_ok ? payload_total : payload_total ^ 8'($urandom_range(1, 255)));
    send_byte(end_ok ? end_char : end_char ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic restore_registers();
    write_reg(REG_BUFFER_CAPACITY, CAPACITY_RESET);
    write_reg(REG_SYNC_CODE, SYNC_CODE_RESET);
    write_reg(REG_START_CODE, START_CODE_RESET);
    write_reg(REG_END_CODE, END_CODE_RESET);
  endtask

  task automatic randomize_registers();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) write_reg(REG_BUFFER_CAPACITY, 8'd255);
    else if (pick < 60) write_reg(REG_BUFFER_CAPACITY, 8'($urandom_range(1, 16)));
    else if (pick < 70) write_reg(REG_BUFFER_CAPACITY, 8'd0);
    else write_reg(REG_BUFFER_CAPACITY, 8'($urandom));
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_SYNC_CODE, SYNC_CODE_RESET);
      write_reg(REG_START_CODE, START_CODE_RESET);
      write_reg(REG_END_CODE, END_CODE_RESET);
    end else begin
      write_reg(REG_SYNC_CODE, 8'($urandom));
      write_reg(REG_START_CODE, 8'($urandom));
      write_reg(REG_END_CODE, 8'($urandom));
    end
  endtask

  task automatic test_basic_frames();
    send_frame(8'd0, random_payload(0), 1'b1, 1'b1, 0);
    send_frame(8'd2, '{8'h00, 8'hFF}, 1'b1, 1'b1, 0);
    send_frame(8'd4, random_payload(4), 1'b1, 1'b1, 0);
  endtask

  task automatic test_length_limits();
    send_frame(8'(MAX_LEN), random_payload(MAX_LEN), 1'b1, 1'b1, 0);
    send_frame(8'(MAX_LEN + 1), random_payload(0), 1'b1, 1'b1, 0);
    send_frame(8'd255, random_payload(0), 1'b1, 1'b1, 0);
  endtask

  task automatic test_frame_errors();
    send_frame(8'd3, random_payload(3), 1'b0, 1'b1, 0);
    send_frame(8'd3, random_payload(3), 1'b1, 1'b0, 0);
    send_frame(8'd0, random_payload(0), 1'b0, 1'b0, 0);
  endtask

  task automatic test_overflow();
    write_reg(REG_BUFFER_CAPACITY, 8'd2);
    send_frame(8'd5, random_payload(5), 1'b1, 1'b1, 0);
    write_reg(REG_BUFFER_CAPACITY, 8'd3);
    send_frame(8'd3, random_payload(3), 1'b1, 1'b1, 0);
    write_reg(REG_BUFFER_CAPACITY, 8'd0);
    send_frame(8'd1, random_payload(1), 1'b1, 1'b1, 0);
    send_frame(8'd0, random_payload(0), 1'b1, 1'b1, 0);
    write_reg(REG_BUFFER_CAPACITY, CAPACITY_RESET);
  endtask

  task automatic test_spaced_sync();
    // Extra sync bytes while waiting for the start byte must be ignored.
    repeat (3) send_byte(sync_char);
    send_noise(2);
    send_frame(8'd2, random_payload(2), 1'b1, 1'b1, 3);
    send_frame(8'd1, random_payload(1), 1'b1, 1'b1, 2);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_SYNC_CODE, 8'hFF);
    write_reg(REG_START_CODE, 8'h00);
    write_reg(REG_END_CODE, 8'hFF);
    send_frame(8'd2, '{8'hFF, 8'h00}, 1'b1, 1'b1, 1);
    write_reg(REG_SYNC_CODE, 8'h00);
    write_reg(REG_START_CODE, 8'hFF);
    write_reg(REG_END_CODE, 8'h00);
    send_frame(8'd1, random_payload(1), 1'b1, 1'b1, 1);
    write_reg(REG_START_CODE, 8'h00);
    send_frame(8'd1, random_payload(1), 1'b1, 1'b1, 0);
    restore_registers();
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int budget);
    int stop_at;
    int frame_count;
    int len;
    sender_idle_pct    = sender_pct;
    receiver_stall_pct = receiver_pct;
    stop_at     = bytes_sent + budget;
    frame_count = 0;
    while (bytes_sent < stop_at) begin
      if (frame_count % 8 == 0) randomize_registers();
      else if (frame_count % 5 == 0) wait_for_results();
      if ($urandom_range(0, 99) < 8) begin
        send_garbage($urandom_range(1, 12));
      end else begin
        len = pick_length();
        send_frame(8'(len), random_payload(len > MAX_LEN ? 0 : len),
                   $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85,
                   $urandom_range(0, 99) < 30 ? 3 : 0);
      end
      frame_count++;
    end
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sender_idle_pct    = 22;
    receiver_stall_pct = 68;
    test_basic_frames();
    test_length_limits();
    test_frame_errors();
    test_overflow();
    test_spaced_sync();
    test_register_extremes();
    test_random_traffic(22, 68, 400);
    test_random_traffic(68, 22, 400);
    test_random_traffic(0, 0, 400);
    wait_for_results();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### stx_etx_frame_receiver.f
src/sfr_pkg.sv
src/stx_etx_frame_receiver.sv
test/tb_top.sv
